>>> rtl/quadrature_knob_decoder_top_defines.svh
`ifndef QUADRATURE_KNOB_DECODER_TOP_DEFINES_SVH
`define QUADRATURE_KNOB_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define QKD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("qkd: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define QKD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("qkd: next-cycle check failed");

`endif

>>> rtl/qkd_pkg.sv
package qkd_pkg;

    localparam int unsigned TIME_W     = 48;
    localparam int unsigned DEBOUNCE_W = 24;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 24'd350000;

    typedef enum logic [1:0] {
        EV_PRESS = 2'd0,
        EV_CW    = 2'd1,
        EV_CCW   = 2'd2
    } t_event_kind;

    // Full-step detent tracker; code 7 is never entered.
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_CW1  = 3'd1,
        PH_CW2  = 3'd2,
        PH_CW3  = 3'd3,
        PH_CCW1 = 3'd4,
        PH_CCW2 = 3'd5,
        PH_CCW3 = 3'd6
    } t_phase;

    // Pin pair, A in bit 1 and B in bit 0.
    localparam logic [1:0] AB_00 = 2'b00;
    localparam logic [1:0] AB_01 = 2'b01;
    localparam logic [1:0] AB_10 = 2'b10;
    localparam logic [1:0] AB_11 = 2'b11;

endpackage

>>> rtl/qkd_in_if.sv
interface qkd_in_if
    import qkd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              button_level;
    logic              phase_a;
    logic              phase_b;
    logic [TIME_W-1:0] time_now;

    modport source (output valid, button_level, phase_a, phase_b, time_now, input ready);
    modport sink   (input valid, button_level, phase_a, phase_b, time_now, output ready);
endinterface

>>> rtl/qkd_out_if.sv
interface qkd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;

    modport source (output valid, event_kind, input ready);
    modport sink   (input valid, event_kind, output ready);
endinterface

>>> rtl/quadrature_knob_decoder_top.sv
// Channel   | Dir | Payload                                      | Handshake
// ----------+-----+----------------------------------------------+-------------
// i_req     | in  | button_level, phase_a, phase_b, time_now[47:0] | valid/ready
// o_evt     | out | event_kind[1:0] (press, cw, ccw)             | valid/ready
// i_cfg_*   | in  | debounce_interval[23:0]                      | write enable
//
// One request per cycle sustained while o_evt is not stalled; a request's event
// (if any) is valid on o_evt after passing the input register, then decode into
// the event register. Throughput is set by the single decode stage that updates
// the detent state and the last-press time.
// i_rst_n is synchronous, active low: phase goes idle, last press time to 0,
// debounce interval to 350000 us, both stages empty.
// A stalled o_evt holds the decode stage; i_req.ready is low for as long as
// the input register holds a request during the stall.
`include "quadrature_knob_decoder_top_defines.svh"

module quadrature_knob_decoder_top
    import qkd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [DEBOUNCE_W-1:0] i_cfg_wdata,
    qkd_in_if.sink                i_req,
    qkd_out_if.source             o_evt
);

    // ---------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------
    logic [DEBOUNCE_W-1:0] r_debounce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RESET;
        end else if (i_cfg_we) begin
            r_debounce <= i_cfg_wdata;
        end
    end

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    logic              r_s1_valid;
    logic              r_s1_button;
    logic [1:0]        r_s1_ab;
    logic [TIME_W-1:0] r_s1_time;

    logic out_free;   // event register empty or being drained
    logic s2_take;    // decode stage consumes the input register
    logic in_take;

    assign out_free    = !o_evt.valid || o_evt.ready;
    assign s2_take     = r_s1_valid && out_free;
    assign i_req.ready = !r_s1_valid || s2_take;
    assign in_take     = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_s1_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_button <= i_req.button_level;
            r_s1_ab     <= {i_req.phase_a, i_req.phase_b};
            r_s1_time   <= i_req.time_now;
        end
    end

    // ---------------------------------------------------------------
    // Decode: debounce check and full-step detent machine
    // ---------------------------------------------------------------
    t_phase            r_phase;
    t_phase            n_phase;
    logic [TIME_W-1:0] r_last_press;
    logic [TIME_W-1:0] n_last_press;
    logic [TIME_W:0]   press_gap;     // extra MSB is the borrow
    logic              press_ok;
    logic              res_valid;
    t_event_kind       res_kind;

    assign press_gap = {1'b0, r_s1_time} - {1'b0, r_last_press};
    // Time running backwards or too soon after the last press: drop it.
    assign press_ok  = !press_gap[TIME_W] &&
                       (press_gap[TIME_W-1:0] >= {{(TIME_W-DEBOUNCE_W){1'b0}}, r_debounce});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_last_press <= '0;
        end else if (s2_take) begin
            r_phase      <= n_phase;
            r_last_press <= n_last_press;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_last_press = r_last_press;
        res_valid    = 1'b0;
        res_kind     = EV_PRESS;
        if (!r_s1_button) begin
            // Pressed: the encoder is not tracked on this sample.
            if (press_ok) begin
                n_last_press = r_s1_time;
                res_valid    = 1'b1;
                res_kind     = EV_PRESS;
            end
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    if (r_s1_ab == AB_01) begin
                        n_phase = PH_CW1;
                    end else if (r_s1_ab == AB_10) begin
                        n_phase = PH_CCW1;
                    end
                end
                PH_CW1: begin
                    if (r_s1_ab == AB_00) begin
                        n_phase = PH_CW2;
                    end else if (r_s1_ab == AB_10) begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_CW2: begin
                    if (r_s1_ab == AB_10) begin
                        n_phase = PH_CW3;
                    end else if (r_s1_ab == AB_11) begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_CW3: begin
                    if (r_s1_ab == AB_11) begin
                        n_phase   = PH_IDLE;
                        res_valid = 1'b1;
                        res_kind  = EV_CW;
                    end
                end
                PH_CCW1: begin
                    if (r_s1_ab == AB_00) begin
                        n_phase = PH_CCW2;
                    end else if (r_s1_ab == AB_11) begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_CCW2: begin
                    if (r_s1_ab == AB_01) begin
                        n_phase = PH_CCW3;
                    end else if (r_s1_ab == AB_11) begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_CCW3: begin
                    if (r_s1_ab == AB_11) begin
                        n_phase   = PH_IDLE;
                        res_valid = 1'b1;
                        res_kind  = EV_CCW;
                    end
                end
                default: begin
                    n_phase = r_phase;   // unreachable code holds
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Event register
    // ---------------------------------------------------------------
    logic        r_out_valid;
    t_event_kind r_out_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s2_take && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_take && res_valid) begin
            r_out_kind <= res_kind;
        end
    end

    assign o_evt.valid      = r_out_valid;
    assign o_evt.event_kind = r_out_kind;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `QKD_ASSERT_NEXT(a_phase_holds_when_idle, i_clk, i_rst_n, !s2_take, $stable(r_phase))
    `QKD_ASSERT_NEXT(a_press_records_time, i_clk, i_rst_n,
        s2_take && !r_s1_button && press_ok, r_last_press == $past(r_s1_time))
    `QKD_ASSERT_NEXT(a_result_reaches_output, i_clk, i_rst_n,
        s2_take && res_valid, r_out_valid && r_out_kind == $past(res_kind))
    `QKD_ASSERT_NOW(a_detent_ends_idle, i_clk, i_rst_n,
        s2_take && res_valid && r_s1_button, n_phase == PH_IDLE)
    `QKD_ASSERT_NOW(a_stall_means_full, i_clk, i_rst_n, !i_req.ready, r_s1_valid && !out_free)

endmodule
